/* src/alloc_size_bucket_stats_unit_assert.svh */
// ----------------------------------------------------------------------------
// alloc_size_bucket_stats_unit_assert.svh
// assertion macros for the allocation size bucket statistics unit
// ----------------------------------------------------------------------------
`ifndef ALLOC_SIZE_BUCKET_STATS_UNIT_ASSERT_SVH
`define ALLOC_SIZE_BUCKET_STATS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at each rising edge, switched off while reset is low
`define ASBS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("asbs assertion failed");
// property checked at each rising edge, reset included
`define ASBS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("asbs assertion failed");
`else
`define ASBS_ASSERT(label, clk, rst_n, prop)
`define ASBS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/asbs_pkg.sv */
// ----------------------------------------------------------------------------
// asbs_pkg
// shared types, codes and sizes of the allocation size bucket statistics unit
// ----------------------------------------------------------------------------
`default_nettype none

package asbs_pkg;

  // table geometry
  localparam int BUCKETS = 16;
  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int CNT_W   = $clog2(BUCKETS + 1);

  // field widths of a beat
  localparam int OP_W        = 3;
  localparam int CTR_W       = 32;
  localparam int BYTE_W      = 48;
  localparam int IN_IDX_W    = 4;
  localparam int SLOT_W      = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int STATUS_W    = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RESET = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_ADD   = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_e;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_MISS,
    CMD_SCAN_INIT,
    CMD_SCAN_STEP,
    CMD_ALLOC,
    CMD_FREE,
    CMD_DUP,
    CMD_SHIFT_INIT,
    CMD_SHIFT_STEP,
    CMD_INSERT,
    CMD_READ_ISSUE,
    CMD_READ_DONE
  } dp_cmd_e;

  // one bucket of the table
  typedef struct packed {
    logic [CTR_W-1:0] size;
    logic [CTR_W-1:0] allocs;
    logic [CTR_W-1:0] frees;
    logic [CTR_W-1:0] peak;
  } entry_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            read_ok;
    logic            scan_done;
    logic            dup;
    logic            shift_done;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/asbs_datapath.sv */
// ----------------------------------------------------------------------------
// asbs_datapath
// bucket memory, scan and shift pointers, byte and count totals, result regs
// ----------------------------------------------------------------------------
`default_nettype none

module asbs_datapath
  import asbs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_cmd_e                cmd_i,
  input  wire logic [OP_W-1:0]        operation_i,
  input  wire logic [CTR_W-1:0]       amount_i,
  input  wire logic [IN_IDX_W-1:0]    bucket_index_i,
  output dp_status_t                  status_o,
  output logic [STATUS_W-1:0]         res_status_o,
  output logic [SLOT_W-1:0]           bucket_slot_o,
  output logic [CTR_W-1:0]            size_limit_o,
  output logic [CTR_W-1:0]            alloc_count_o,
  output logic [CTR_W-1:0]            free_count_o,
  output logic [CTR_W-1:0]            peak_outstanding_o,
  output logic [BYTE_W-1:0]           bytes_in_use_o,
  output logic [BYTE_W-1:0]           peak_bytes_o,
  output logic [CTR_W-1:0]            total_outstanding_o,
  output logic [COUNT_OUT_W-1:0]      bucket_count_o
);

  // saturating increment of a counter
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + CTR_W'(1);
  endfunction

  // captured beat
  logic [OP_W-1:0]     op_q, op_d;
  logic [CTR_W-1:0]    amt_q, amt_d;
  logic [IN_IDX_W-1:0] idx_q, idx_d;

  // totals
  logic [CNT_W-1:0]  used_q, used_d;
  logic [BYTE_W-1:0] bytes_q, bytes_d;
  logic [BYTE_W-1:0] bpeak_q, bpeak_d;
  logic [CTR_W-1:0]  outst_q, outst_d;

  // scan and shift pointers
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             found_q, found_d;
  logic [CNT_W-1:0] b_q, b_d;
  entry_t           ent_q, ent_d;
  logic [CNT_W-1:0] sh_k_q, sh_k_d;
  logic             sh_vld_q, sh_vld_d;
  logic [IDX_W-1:0] sh_dst_q, sh_dst_d;

  // result registers
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  entry_t            res_ent_q, res_ent_d;

  // bucket memory, one read and one write port
  entry_t           bucket_mem_q [BUCKETS];
  entry_t           rd_data_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // derived values
  logic             hit;
  logic             exhausted;
  logic             full;
  logic [CNT_W-1:0] sh_prev;
  entry_t           alloc_base;
  entry_t           alloc_ent;
  entry_t           free_ent;
  entry_t           insert_ent;
  logic             alloc_ok;
  logic [CTR_W-1:0] alloc_inc;
  logic [CTR_W-1:0] cur_out;
  logic [BYTE_W:0]  bytes_sum;
  logic [BYTE_W-1:0] bytes_add;
  logic [BYTE_W-1:0] bytes_sub;

  // scan compare on the registered read data
  assign hit       = rd_vld_q && (rd_data_q.size >= amt_q);
  assign exhausted = !rd_vld_q && (scan_idx_q >= used_q);
  assign full      = (used_q == CNT_W'(BUCKETS));
  assign sh_prev   = sh_k_q - CNT_W'(1);

  // alloc update: found bucket or a fresh one appended
  assign alloc_ok   = found_q || !full;
  assign alloc_base = found_q ? ent_q
                              : entry_t'{size: amt_q, allocs: '0, frees: '0, peak: '0};
  assign alloc_inc  = sat_inc(alloc_base.allocs);
  assign cur_out    = (alloc_inc > alloc_base.frees) ? alloc_inc - alloc_base.frees : '0;
  assign alloc_ent  = '{size:   alloc_base.size,
                        allocs: alloc_inc,
                        frees:  alloc_base.frees,
                        peak:   (cur_out > alloc_base.peak) ? cur_out : alloc_base.peak};
  assign free_ent   = '{size: ent_q.size, allocs: ent_q.allocs,
                        frees: sat_inc(ent_q.frees), peak: ent_q.peak};
  assign insert_ent = '{size: amt_q, allocs: '0, frees: '0, peak: '0};

  // byte totals, saturating at the top and clamping at zero
  assign bytes_sum = {1'b0, bytes_q} + (BYTE_W + 1)'(amt_q);
  assign bytes_add = bytes_sum[BYTE_W] ? '1 : bytes_sum[BYTE_W-1:0];
  assign bytes_sub = (bytes_q > BYTE_W'(amt_q)) ? bytes_q - BYTE_W'(amt_q) : '0;

  // next state per command
  always_comb begin
    op_d         = op_q;
    amt_d        = amt_q;
    idx_d        = idx_q;
    used_d       = used_q;
    bytes_d      = bytes_q;
    bpeak_d      = bpeak_q;
    outst_d      = outst_q;
    scan_idx_d   = scan_idx_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    b_d          = b_q;
    ent_d        = ent_q;
    sh_k_d       = sh_k_q;
    sh_vld_d     = 1'b0;
    sh_dst_d     = sh_dst_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_ent_d    = res_ent_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;

    // shifted entry is written in the cycle after its read
    if (sh_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = sh_dst_q;
      wr_data = rd_data_q;
    end

    unique case (cmd_i)
      CMD_LOAD: begin
        op_d  = operation_i;
        amt_d = amount_i;
        idx_d = bucket_index_i;
      end
      CMD_CLEAR: begin
        used_d       = '0;
        bytes_d      = '0;
        bpeak_d      = '0;
        outst_d      = '0;
        res_status_d = ST_OK;
        res_slot_d   = '0;
        res_ent_d    = '0;
      end
      CMD_MISS: begin
        res_status_d = ST_MISS;
        res_slot_d   = (op_q == OP_READ) ? SLOT_W'(idx_q) : '0;
        res_ent_d    = '0;
      end
      CMD_SCAN_INIT: begin
        scan_idx_d = '0;
        found_d    = 1'b0;
        b_d        = used_q;
      end
      CMD_SCAN_STEP: begin
        if (hit) begin
          found_d = 1'b1;
          b_d     = CNT_W'(rd_idx_q);
          ent_d   = rd_data_q;
        end else if (scan_idx_q < used_q) begin
          rd_en      = 1'b1;
          rd_addr    = scan_idx_q[IDX_W-1:0];
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end
      end
      CMD_ALLOC: begin
        bytes_d = bytes_add;
        bpeak_d = (bytes_add > bpeak_q) ? bytes_add : bpeak_q;
        if (alloc_ok) begin
          wr_en        = 1'b1;
          wr_addr      = b_q[IDX_W-1:0];
          wr_data      = alloc_ent;
          outst_d      = sat_inc(outst_q);
          used_d       = found_q ? used_q : used_q + CNT_W'(1);
          res_status_d = ST_OK;
          res_slot_d   = SLOT_W'(b_q);
          res_ent_d    = alloc_ent;
        end else begin
          res_status_d = ST_MISS;
          res_slot_d   = '0;
          res_ent_d    = '0;
        end
      end
      CMD_FREE: begin
        bytes_d = bytes_sub;
        if (found_q) begin
          wr_en        = 1'b1;
          wr_addr      = b_q[IDX_W-1:0];
          wr_data      = free_ent;
          outst_d      = (outst_q != '0) ? outst_q - CTR_W'(1) : outst_q;
          res_status_d = ST_OK;
          res_slot_d   = SLOT_W'(b_q);
          res_ent_d    = free_ent;
        end else begin
          res_status_d = ST_MISS;
          res_slot_d   = '0;
          res_ent_d    = '0;
        end
      end
      CMD_DUP: begin
        res_status_d = ST_DUP;
        res_slot_d   = SLOT_W'(b_q);
        res_ent_d    = ent_q;
      end
      CMD_SHIFT_INIT: begin
        sh_k_d = used_q;
      end
      CMD_SHIFT_STEP: begin
        if (sh_k_q > b_q) begin
          rd_en    = 1'b1;
          rd_addr  = sh_prev[IDX_W-1:0];
          sh_vld_d = 1'b1;
          sh_dst_d = sh_k_q[IDX_W-1:0];
          sh_k_d   = sh_prev;
        end
      end
      CMD_INSERT: begin
        wr_en        = 1'b1;
        wr_addr      = b_q[IDX_W-1:0];
        wr_data      = insert_ent;
        used_d       = used_q + CNT_W'(1);
        res_status_d = ST_OK;
        res_slot_d   = SLOT_W'(b_q);
        res_ent_d    = insert_ent;
      end
      CMD_READ_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(idx_q);
      end
      CMD_READ_DONE: begin
        res_status_d = ST_OK;
        res_slot_d   = SLOT_W'(idx_q);
        res_ent_d    = rd_data_q;
      end
      default: begin
      end
    endcase
  end

  // totals and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      bytes_q  <= '0;
      bpeak_q  <= '0;
      outst_q  <= '0;
      rd_vld_q <= 1'b0;
      sh_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      used_q   <= used_d;
      bytes_q  <= bytes_d;
      bpeak_q  <= bpeak_d;
      outst_q  <= outst_d;
      rd_vld_q <= rd_vld_d;
      sh_vld_q <= sh_vld_d;
      found_q  <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    amt_q        <= amt_d;
    idx_q        <= idx_d;
    scan_idx_q   <= scan_idx_d;
    rd_idx_q     <= rd_idx_d;
    b_q          <= b_d;
    ent_q        <= ent_d;
    sh_k_q       <= sh_k_d;
    sh_dst_q     <= sh_dst_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_ent_q    <= res_ent_d;
  end

  // bucket memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bucket_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= bucket_mem_q[rd_addr];
    end
  end

  // status towards the controller
  assign status_o = '{op:         op_q,
                      full:       full,
                      read_ok:    (32'(idx_q) < 32'(used_q)),
                      scan_done:  hit || exhausted,
                      dup:        found_q && (ent_q.size == amt_q),
                      shift_done: !sh_vld_q && (sh_k_q == b_q)};

  // result and total outputs
  assign res_status_o        = res_status_q;
  assign bucket_slot_o       = res_slot_q;
  assign size_limit_o        = res_ent_q.size;
  assign alloc_count_o       = res_ent_q.allocs;
  assign free_count_o        = res_ent_q.frees;
  assign peak_outstanding_o  = res_ent_q.peak;
  assign bytes_in_use_o      = bytes_q;
  assign peak_bytes_o        = bpeak_q;
  assign total_outstanding_o = outst_q;
  assign bucket_count_o      = COUNT_OUT_W'(used_q);

endmodule

`default_nettype wire

/* src/asbs_ctrl.sv */
// ----------------------------------------------------------------------------
// asbs_ctrl
// controller: sequences decode, bucket scan, insertion shift and result beat
// ----------------------------------------------------------------------------
`default_nettype none

module asbs_ctrl
  import asbs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output dp_cmd_e         cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state and command
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_e'(status_i.op))
          OP_RESET: begin
            cmd_o   = CMD_CLEAR;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
          OP_ALLOC, OP_FREE: begin
            cmd_o   = CMD_SCAN_INIT;
            state_d = S_SCAN;
          end
          OP_ADD: begin
            if (status_i.full) begin
              cmd_o   = CMD_MISS;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              cmd_o   = CMD_SCAN_INIT;
              state_d = S_SCAN;
            end
          end
          OP_READ: begin
            if (status_i.read_ok) begin
              cmd_o   = CMD_READ_ISSUE;
              state_d = S_READ;
            end else begin
              cmd_o   = CMD_MISS;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          end
          default: begin
            cmd_o   = CMD_MISS;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN_STEP;
        if (status_i.scan_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        unique case (op_e'(status_i.op))
          OP_ALLOC: begin
            cmd_o   = CMD_ALLOC;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
          OP_FREE: begin
            cmd_o   = CMD_FREE;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
          OP_ADD: begin
            if (status_i.dup) begin
              cmd_o   = CMD_DUP;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              cmd_o   = CMD_SHIFT_INIT;
              state_d = S_SHIFT;
            end
          end
          default: begin
            cmd_o   = CMD_MISS;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        if (status_i.shift_done) begin
          cmd_o   = CMD_INSERT;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          cmd_o = CMD_SHIFT_STEP;
        end
      end
      S_READ: begin
        cmd_o   = CMD_READ_DONE;
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

/* src/alloc_size_bucket_stats_unit.sv */
// done_o pulses once a beat is finished: reset and rejected operations end
// straight after decode, a bucket read after its memory read, an alloc or
// free after a scan up to the bucket it lands in (the whole table when none
// fits); an insertion also moves each bucket above its slot up by one place.
// Beats are taken one at a time while busy is low, the next in the done_o cycle.
// Reset (rst_ni low) empties the table and clears all totals at once.
// ----------------------------------------------------------------------------
// alloc_size_bucket_stats_unit
// allocation monitor with a sorted table of size buckets and byte totals
// ----------------------------------------------------------------------------
`default_nettype none

`include "alloc_size_bucket_stats_unit_assert.svh"

module alloc_size_bucket_stats_unit
  import asbs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [OP_W-1:0]        operation_i,
  input  wire logic [CTR_W-1:0]       amount_i,
  input  wire logic [IN_IDX_W-1:0]    bucket_index_i,
  output logic                        done_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [SLOT_W-1:0]           bucket_slot_o,
  output logic [CTR_W-1:0]            size_limit_o,
  output logic [CTR_W-1:0]            alloc_count_o,
  output logic [CTR_W-1:0]            free_count_o,
  output logic [CTR_W-1:0]            peak_outstanding_o,
  output logic [BYTE_W-1:0]           bytes_in_use_o,
  output logic [BYTE_W-1:0]           peak_bytes_o,
  output logic [CTR_W-1:0]            total_outstanding_o,
  output logic [COUNT_OUT_W-1:0]      bucket_count_o
);

  dp_cmd_e    cmd;
  dp_status_t dp_status;

  // controller
  asbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // datapath
  asbs_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .operation_i         (operation_i),
    .amount_i            (amount_i),
    .bucket_index_i      (bucket_index_i),
    .status_o            (dp_status),
    .res_status_o        (status_o),
    .bucket_slot_o       (bucket_slot_o),
    .size_limit_o        (size_limit_o),
    .alloc_count_o       (alloc_count_o),
    .free_count_o        (free_count_o),
    .peak_outstanding_o  (peak_outstanding_o),
    .bytes_in_use_o      (bytes_in_use_o),
    .peak_bytes_o        (peak_bytes_o),
    .total_outstanding_o (total_outstanding_o),
    .bucket_count_o      (bucket_count_o)
  );

  // result beat only while idle, taken beat always starts work
  `ASBS_ASSERT(a_done_when_idle, clk_i, rst_ni, done_o |-> !busy)
  `ASBS_ASSERT(a_accept_goes_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // byte peak never below current usage, table never overfilled
  `ASBS_ASSERT(a_peak_covers_use, clk_i, rst_ni, peak_bytes_o >= bytes_in_use_o)
  `ASBS_ASSERT(a_count_in_range, clk_i, rst_ni, 32'(bucket_count_o) <= 32'(BUCKETS))

endmodule

`default_nettype wire

/* verif/asbs_result_checker.sv */
// ----------------------------------------------------------------------------
// asbs_result_checker
// predicts the bucket report of every accepted command beat and compares it
// field by field with the report beat that the unit returns
// ----------------------------------------------------------------------------
`default_nettype none

module asbs_result_checker
  import asbs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   busy_i,
  input  wire logic [OP_W-1:0]        operation_i,
  input  wire logic [CTR_W-1:0]       amount_i,
  input  wire logic [IN_IDX_W-1:0]    bucket_index_i,
  input  wire logic                   done_i,
  input  wire logic [STATUS_W-1:0]    status_i,
  input  wire logic [SLOT_W-1:0]      bucket_slot_i,
  input  wire logic [CTR_W-1:0]       size_limit_i,
  input  wire logic [CTR_W-1:0]       alloc_count_i,
  input  wire logic [CTR_W-1:0]       free_count_i,
  input  wire logic [CTR_W-1:0]       peak_outstanding_i,
  input  wire logic [BYTE_W-1:0]      bytes_in_use_i,
  input  wire logic [BYTE_W-1:0]      peak_bytes_i,
  input  wire logic [CTR_W-1:0]       total_outstanding_i,
  input  wire logic [COUNT_OUT_W-1:0] bucket_count_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one report beat as the unit presents it
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [CTR_W-1:0]       size;
    logic [CTR_W-1:0]       allocs;
    logic [CTR_W-1:0]       frees;
    logic [CTR_W-1:0]       peak;
    logic [BYTE_W-1:0]      bytes;
    logic [BYTE_W-1:0]      bytes_pk;
    logic [CTR_W-1:0]       total;
    logic [COUNT_OUT_W-1:0] count;
  } bucket_report_t;

  // shadow copy of the bucket table and totals
  logic [CTR_W-1:0]  tbl_size   [BUCKETS];
  logic [CTR_W-1:0]  tbl_allocs [BUCKETS];
  logic [CTR_W-1:0]  tbl_frees  [BUCKETS];
  logic [CTR_W-1:0]  tbl_peak   [BUCKETS];
  int unsigned       n_used;
  logic [BYTE_W-1:0] live_bytes;
  logic [BYTE_W-1:0] live_peak;
  logic [CTR_W-1:0]  live_total;

  bucket_report_t expected_reports[$];
  bucket_report_t got_report;
  bucket_report_t want_report;
  int             fails = 0;
  int             waiting = 0;

  function automatic logic [CTR_W-1:0] sat_inc(logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_state();
    for (int k = 0; k < BUCKETS; k++) begin
      tbl_size[k]   = '0;
      tbl_allocs[k] = '0;
      tbl_frees[k]  = '0;
      tbl_peak[k]   = '0;
    end
    n_used     = 0;
    live_bytes = '0;
    live_peak  = '0;
    live_total = '0;
  endfunction

  // first used bucket at least amt in size, n_used when none fits
  function automatic int unsigned first_fit(logic [CTR_W-1:0] amt);
    for (int unsigned b = 0; b < n_used; b++) begin
      if (tbl_size[b] >= amt) return b;
    end
    return n_used;
  endfunction

  // updates the shadow table for one command beat and returns its report
  function automatic bucket_report_t apply_beat(logic [OP_W-1:0] op,
                                                logic [CTR_W-1:0] amt,
                                                logic [IN_IDX_W-1:0] idx);
    bucket_report_t r;
    int unsigned    b;
    int             hit;
    logic [BYTE_W:0] sum;
    logic [CTR_W-1:0] diff;
    r   = '0;
    hit = -1;
    case (op)
      OP_RESET: clear_state();
      OP_ALLOC: begin
        b = first_fit(amt);
        // no fit: append a bucket of exactly this size while there is room
        if (b >= n_used && n_used < BUCKETS) begin
          b = n_used;
          tbl_size[b]   = amt;
          tbl_allocs[b] = '0;
          tbl_frees[b]  = '0;
          tbl_peak[b]   = '0;
          n_used++;
        end
        if (b < n_used) begin
          tbl_allocs[b] = sat_inc(tbl_allocs[b]);
          diff = (tbl_allocs[b] > tbl_frees[b]) ? tbl_allocs[b] - tbl_frees[b] : '0;
          if (diff > tbl_peak[b]) tbl_peak[b] = diff;
          live_total = sat_inc(live_total);
          hit = b;
        end else begin
          r.status = ST_MISS;
        end
        // bytes count even when no bucket took the alloc
        sum = {1'b0, live_bytes} + amt;
        live_bytes = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
        if (live_bytes > live_peak) live_peak = live_bytes;
      end
      OP_FREE: begin
        b = first_fit(amt);
        if (b < n_used) begin
          tbl_frees[b] = sat_inc(tbl_frees[b]);
          if (live_total != '0) live_total = live_total - 1'b1;
          hit = b;
        end else begin
          r.status = ST_MISS;
        end
        live_bytes = (live_bytes > amt) ? live_bytes - amt : '0;
      end
      OP_ADD: begin
        if (n_used >= BUCKETS) begin
          r.status = ST_MISS;
        end else begin
          b = first_fit(amt);
          if (b < n_used && tbl_size[b] == amt) begin
            r.status = ST_DUP;
            hit = b;
          end else begin
            // open a gap at slot b by moving the larger buckets up
            for (int unsigned k = n_used; k > b; k--) begin
              tbl_size[k]   = tbl_size[k-1];
              tbl_allocs[k] = tbl_allocs[k-1];
              tbl_frees[k]  = tbl_frees[k-1];
              tbl_peak[k]   = tbl_peak[k-1];
            end
            tbl_size[b]   = amt;
            tbl_allocs[b] = '0;
            tbl_frees[b]  = '0;
            tbl_peak[b]   = '0;
            n_used++;
            hit = b;
          end
        end
      end
      OP_READ: begin
        if (idx < n_used) begin
          hit = idx;
        end else begin
          r.status = ST_MISS;
          r.slot   = idx;
        end
      end
      default: r.status = ST_MISS;
    endcase

    if (hit >= 0) begin
      r.slot   = SLOT_W'(hit);
      r.size   = tbl_size[hit];
      r.allocs = tbl_allocs[hit];
      r.frees  = tbl_frees[hit];
      r.peak   = tbl_peak[hit];
    end
    r.bytes    = live_bytes;
    r.bytes_pk = live_peak;
    r.total    = live_total;
    r.count    = COUNT_OUT_W'(n_used);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  // gather the report beat from the ports
  always_comb begin
    got_report.status   = status_i;
    got_report.slot     = bucket_slot_i;
    got_report.size     = size_limit_i;
    got_report.allocs   = alloc_count_i;
    got_report.frees    = free_count_i;
    got_report.peak     = peak_outstanding_i;
    got_report.bytes    = bytes_in_use_i;
    got_report.bytes_pk = peak_bytes_i;
    got_report.total    = total_outstanding_i;
    got_report.count    = bucket_count_i;
  end

  // compare each report beat, then predict the command beat taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_reports.delete();
      waiting = 0;
    end else begin
      if (done_i) begin
        if (expected_reports.size() == 0) begin
          $error("report beat with no command beat waiting");
          fails++;
        end else begin
          want_report = expected_reports.pop_front();
          check_field("status", want_report.status, got_report.status);
          check_field("bucket_slot", want_report.slot, got_report.slot);
          check_field("size_limit", want_report.size, got_report.size);
          check_field("alloc_count", want_report.allocs, got_report.allocs);
          check_field("free_count", want_report.frees, got_report.frees);
          check_field("peak_outstanding", want_report.peak, got_report.peak);
          check_field("bytes_in_use", want_report.bytes, got_report.bytes);
          check_field("peak_bytes", want_report.bytes_pk, got_report.bytes_pk);
          check_field("total_outstanding", want_report.total, got_report.total);
          check_field("bucket_count", want_report.count, got_report.count);
        end
      end
      if (start_i && !busy_i) begin
        expected_reports.push_back(apply_beat(operation_i, amount_i, bucket_index_i));
      end
      waiting = expected_reports.size();
    end
    pending_o    <= waiting;
    fail_count_o <= fails;
  end

endmodule

`default_nettype wire

/* verif/tb_alloc_size_bucket_stats_unit.sv */
// ----------------------------------------------------------------------------
// tb_alloc_size_bucket_stats_unit
// drives command beats into the allocation size bucket unit: a directed walk
// through empty, duplicate, full and clamped cases, a random mix of allocs,
// frees, inserts, reads, resets and undefined codes with random gaps, and a
// short back-to-back burst of maximal allocs; a checker beside the unit
// predicts and compares every report beat
// ----------------------------------------------------------------------------
`default_nettype none

module tb_alloc_size_bucket_stats_unit
  import asbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // operation codes the unit does not define
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_BEATS = 850;
  localparam int QUIET_LO     = 350;
  localparam int QUIET_HI     = 550;
  localparam int BURST_BEATS  = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [CTR_W-1:0] MAX_AMOUNT = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [OP_W-1:0]        operation;
  logic [CTR_W-1:0]       amount;
  logic [IN_IDX_W-1:0]    bucket_index;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_W-1:0]      bucket_slot;
  logic [CTR_W-1:0]       size_limit;
  logic [CTR_W-1:0]       alloc_count;
  logic [CTR_W-1:0]       free_count;
  logic [CTR_W-1:0]       peak_outstanding;
  logic [BYTE_W-1:0]      bytes_in_use;
  logic [BYTE_W-1:0]      peak_bytes;
  logic [CTR_W-1:0]       total_outstanding;
  logic [COUNT_OUT_W-1:0] bucket_count;
  int                     fail_count;
  int                     pending;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  alloc_size_bucket_stats_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation),
    .amount_i            (amount),
    .bucket_index_i      (bucket_index),
    .done_o              (done),
    .status_o            (status),
    .bucket_slot_o       (bucket_slot),
    .size_limit_o        (size_limit),
    .alloc_count_o       (alloc_count),
    .free_count_o        (free_count),
    .peak_outstanding_o  (peak_outstanding),
    .bytes_in_use_o      (bytes_in_use),
    .peak_bytes_o        (peak_bytes),
    .total_outstanding_o (total_outstanding),
    .bucket_count_o      (bucket_count)
  );

  asbs_result_checker u_result_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .busy_i              (busy),
    .operation_i         (operation),
    .amount_i            (amount),
    .bucket_index_i      (bucket_index),
    .done_i              (done),
    .status_i            (status),
    .bucket_slot_i       (bucket_slot),
    .size_limit_i        (size_limit),
    .alloc_count_i       (alloc_count),
    .free_count_i        (free_count),
    .peak_outstanding_i  (peak_outstanding),
    .bytes_in_use_i      (bytes_in_use),
    .peak_bytes_i        (peak_bytes),
    .total_outstanding_i (total_outstanding),
    .bucket_count_i      (bucket_count),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // present one command beat and hold it until the unit takes it
  task automatic send_beat(logic [OP_W-1:0] op, logic [CTR_W-1:0] amt,
                           logic [IN_IDX_W-1:0] idx);
    start        <= 1'b1;
    operation    <= op;
    amount       <= amt;
    bucket_index <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  // random gap with junk on the fields, skipped inside the quiet stretch
  task automatic pace(bit quiet);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 34) gap = $urandom_range(24, 1);
    if (gap != 0) begin
      start        <= 1'b0;
      operation    <= OP_W'($urandom);
      amount       <= $urandom;
      bucket_index <= IN_IDX_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // bucket sizes that recur, so that hits, duplicates and full tables are common
  function automatic logic [CTR_W-1:0] pool_size(int unsigned k);
    case (k)
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd8;
      3:       return 32'd16;
      4:       return 32'd24;
      5:       return 32'd32;
      6:       return 32'd48;
      7:       return 32'd64;
      8:       return 32'd96;
      9:       return 32'd128;
      10:      return 32'd256;
      11:      return 32'd1024;
      12:      return 32'd4096;
      13:      return 32'd65536;
      14:      return 32'h8000_0000;
      default: return MAX_AMOUNT;
    endcase
  endfunction

  function automatic logic [CTR_W-1:0] pick_amount();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return pool_size($urandom_range(15));
    if (sel < 65) return pool_size($urandom_range(15)) + 1'b1;
    if (sel < 75) return pool_size($urandom_range(15)) - 1'b1;
    if (sel < 90) return $urandom;
    return $urandom_range(4095);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return OP_ALLOC;
    if (sel < 64) return OP_FREE;
    if (sel < 76) return OP_ADD;
    if (sel < 94) return OP_READ;
    if (sel < 96) return OP_RESET;
    return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
  endfunction

  // stimulus and verdict
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation    = OP_RESET;
    amount       = '0;
    bucket_index = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table: read and free miss, free clamps bytes at zero
    send_beat(OP_READ, 32'd0, 4'd0);           pace(0);
    send_beat(OP_FREE, 32'd100, 4'd3);         pace(0);
    // appends at both size extremes, then a hit in the top bucket
    send_beat(OP_ALLOC, 32'd0, 4'd15);         pace(0);
    send_beat(OP_ALLOC, MAX_AMOUNT, 4'd0);     pace(0);
    send_beat(OP_ALLOC, 32'd100, 4'd7);        pace(0);
    // insert in the middle, then duplicates
    send_beat(OP_ADD, 32'd64, 4'd0);           pace(0);
    send_beat(OP_ADD, 32'd64, 4'd0);           pace(0);
    send_beat(OP_ADD, 32'd0, 4'd0);            pace(0);
    send_beat(OP_READ, 32'd0, 4'd2);           pace(0);
    send_beat(OP_READ, MAX_AMOUNT, 4'd15);     pace(0);
    // frees past the allocs of a bucket and past the bytes in use
    send_beat(OP_FREE, 32'd64, 4'd1);          pace(0);
    send_beat(OP_FREE, 32'd64, 4'd1);          pace(0);
    send_beat(OP_FREE, MAX_AMOUNT, 4'd1);      pace(0);
    send_beat(OP_SPARE_LO, 32'd5, 4'd5);       pace(0);
    send_beat(OP_SPARE_HI, 32'd7, 4'd10);      pace(0);
    send_beat(OP_RESET, MAX_AMOUNT, 4'd15);    pace(0);
    // fill the table from the top down, each insert shifting every bucket
    for (int k = BUCKETS; k >= 1; k--) begin
      send_beat(OP_ADD, CTR_W'(k * 1000), 4'd0);
      pace(0);
    end
    // full table: add and an alloc that fits nowhere both miss
    send_beat(OP_ADD, 32'd5, 4'd0);            pace(0);
    send_beat(OP_ALLOC, MAX_AMOUNT, 4'd0);     pace(0);
    send_beat(OP_READ, 32'd0, 4'd15);          pace(0);

    // random mix
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      send_beat(pick_op(), pick_amount(), IN_IDX_W'($urandom));
      pace(n >= QUIET_LO && n < QUIET_HI);
    end

    // back-to-back maximal allocs into one bucket
    send_beat(OP_RESET, 32'd0, 4'd0);
    for (int n = 0; n < BURST_BEATS; n++) begin
      send_beat(OP_ALLOC, MAX_AMOUNT, 4'd0);
    end
    send_beat(OP_FREE, MAX_AMOUNT, 4'd0);
    send_beat(OP_READ, 32'd0, 4'd0);
    start <= 1'b0;

    // drain the outstanding reports
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
